[design/tpd_pkg.sv]
package tpd_pkg;

  // Widths of the preamble window, the position count and the result fields.
  localparam int unsigned MAX_PREAMBLE_BITS = 64;
  localparam int unsigned POSITION_BITS     = 16;
  localparam int unsigned LEN_W             = 7;
  localparam int unsigned POS_W             = POSITION_BITS + 1;
  localparam int unsigned START_W           = 16;
  localparam int unsigned DATA_W            = 64;
  localparam int unsigned ADDR_W            = 5;

  // The agreeing bits are summed in groups before the final total.
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned NUM_GROUPS = MAX_PREAMBLE_BITS / GROUP_SIZE;
  localparam int unsigned GROUP_W    = $clog2(GROUP_SIZE + 1);
  localparam int unsigned COUNT_W    = $clog2(MAX_PREAMBLE_BITS + 1);

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_PATTERN = 2'd0,
    REG_LENGTH  = 2'd1,
    REG_MIN     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic data_bit;
    logic end_of_block;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic               not_found;
    logic [START_W-1:0] start_index;
  } out_word_t;

  // Per-word side information that travels with the agree vector.
  typedef struct packed {
    logic               last;
    logic               eligible;
    logic [LEN_W-1:0]   need;
    logic [START_W-1:0] start;
  } side_t;

endpackage

[design/tpd_cell.sv]
module tpd_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic load_i,
  input  logic clear_i,
  input  logic prev_i,
  input  logic ref_i,
  input  logic care_i,
  output logic bit_o,
  output logic agree_o
);

  logic hist_q, hist_d;
  logic agree_q, agree_d;

  // The bit entering this cell is compared with its aligned pattern bit.
  assign agree_d = care_i & ~(prev_i ^ ref_i);
  assign hist_d  = clear_i ? 1'b0 : prev_i;

  // History bit: takes the neighbor's bit (cell zero: the input bit) on each accepted word, or zero at a block's end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= 1'b0;
    end else if (shift_i) begin
      hist_q <= hist_d;
    end
  end

  // Compare result for the word now in the first stage.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      agree_q <= agree_d;
    end
  end

  assign bit_o   = hist_q;
  assign agree_o = agree_q;

endmodule

[design/tpd_count.sv]
module tpd_count (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [tpd_pkg::MAX_PREAMBLE_BITS-1:0] agree_i,
  input  tpd_pkg::side_t                        side_i,
  output logic                                  valid_o,
  output tpd_pkg::out_word_t                    result_o
);
  import tpd_pkg::*;

  logic                 valid_q;
  side_t                side_q;
  logic [GROUP_W-1:0]   sums_q [NUM_GROUPS];
  logic [GROUP_W-1:0]   sums_d [NUM_GROUPS];
  logic [COUNT_W-1:0]   total;
  logic                 seen_q, seen_d;
  logic                 found;
  logic                 not_found;

  // Group sums of the agree vector.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      sums_d[g] = '0;
      for (int b = 0; b < GROUP_SIZE; b++) begin
        sums_d[g] = sums_d[g] + GROUP_W'(agree_i[g*GROUP_SIZE + b]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        sums_q[g] <= sums_d[g];
      end
    end
  end

  // Final total and the threshold decision.
  always_comb begin
    total = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total = total + COUNT_W'(sums_q[g]);
    end
  end

  assign found     = valid_q & ~seen_q & side_q.eligible & (total >= side_q.need);
  assign not_found = valid_q & side_q.last & ~seen_q & ~found;
  assign seen_d    = side_q.last ? 1'b0 : (seen_q | found);

  // The match flag is kept in word order at the last stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (en_i && valid_q) begin
      seen_q <= seen_d;
    end
  end

  assign valid_o               = valid_q;
  assign result_o.found        = found;
  assign result_o.not_found    = not_found;
  assign result_o.start_index  = found ? side_q.start : '0;

endmodule

[design/tolerant_preamble_detector.sv]
// Channel   Direction  Signals
// in        input      in_valid_i, in_ready_o, in_data_i (data_bit, end_of_block)
// out       output     out_valid_o, out_ready_i, out_data_o (found, not_found, start_index)
// config    APB        psel_i, penable_i, pwrite_i, paddr_i, pwdata_i, prdata_o, pready_o
//
// One word is accepted per cycle while the output register is empty or taken; each result
// word passes through the cell compare stage, the group sum stage and the output register.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset clears the history cells, the position count, the match flag and all valid bits.
// Registers sit at byte addresses 0, 8 and 16 and read back their value.
module tolerant_preamble_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tpd_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tpd_pkg::out_word_t              out_data_o,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [tpd_pkg::ADDR_W-1:0]      paddr_i,
  input  logic [tpd_pkg::DATA_W-1:0]      pwdata_i,
  output logic [tpd_pkg::DATA_W-1:0]      prdata_o,
  output logic                            pready_o
);
  import tpd_pkg::*;

  logic [MAX_PREAMBLE_BITS-1:0] pattern_q;
  logic [LEN_W-1:0]             length_q;
  logic [LEN_W-1:0]             min_q;
  reg_idx_e                     reg_idx;
  logic                         cfg_write;

  logic                         en;
  logic                         accept;
  logic [POS_W-1:0]             pos_q, pos_d, pos_new;
  logic [LEN_W-1:0]             len_eff;
  logic [LEN_W-1:0]             need_eff;
  logic [MAX_PREAMBLE_BITS-1:0] reversed;
  logic [MAX_PREAMBLE_BITS-1:0] aligned;
  logic [MAX_PREAMBLE_BITS-1:0] care;
  logic [MAX_PREAMBLE_BITS-1:0] hist;
  logic [MAX_PREAMBLE_BITS-1:0] prev;
  logic [MAX_PREAMBLE_BITS-1:0] agree;
  logic [POS_W-1:0]             start_full;

  logic                         valid_a_q;
  side_t                        side_a_q, side_a_d;
  logic                         valid_b;
  out_word_t                    result_b;
  logic                         out_valid_q;
  out_word_t                    out_q;

  // Configuration port decode and registers.
  assign reg_idx   = reg_idx_e'(paddr_i[ADDR_W-1:3]);
  assign cfg_write = psel_i & penable_i & pwrite_i;
  assign pready_o  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= MAX_PREAMBLE_BITS'(60);
      length_q  <= LEN_W'(8);
      min_q     <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PATTERN: pattern_q <= pwdata_i[MAX_PREAMBLE_BITS-1:0];
        REG_LENGTH:  length_q  <= pwdata_i[LEN_W-1:0];
        REG_MIN:     min_q     <= pwdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN: prdata_o = DATA_W'(pattern_q);
      REG_LENGTH:  prdata_o = DATA_W'(length_q);
      REG_MIN:     prdata_o = DATA_W'(min_q);
      default:     prdata_o = '0;
    endcase
  end

  // Effective length and threshold.
  assign len_eff  = (length_q > LEN_W'(MAX_PREAMBLE_BITS)) ? LEN_W'(MAX_PREAMBLE_BITS)
                                                           : length_q;
  assign need_eff = (min_q == '0 || min_q > len_eff) ? len_eff : min_q;

  // Pattern aligned to the history: cell k sees pattern bit (length - 1 - k).
  always_comb begin
    for (int k = 0; k < MAX_PREAMBLE_BITS; k++) begin
      reversed[k] = pattern_q[MAX_PREAMBLE_BITS-1-k];
    end
  end
  assign aligned = reversed >> (LEN_W'(MAX_PREAMBLE_BITS) - len_eff);
  assign care    = ~({MAX_PREAMBLE_BITS{1'b1}} << len_eff);

  // Pipeline enable and input handshake.
  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i & en;

  // Row of history cells; the newest bit enters cell zero.
  assign prev = {hist[MAX_PREAMBLE_BITS-2:0], in_data_i.data_bit};

  for (genvar k = 0; k < MAX_PREAMBLE_BITS; k++) begin : g_cell
    tpd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .load_i  (en),
      .clear_i (in_data_i.end_of_block),
      .prev_i  (prev[k]),
      .ref_i   (aligned[k]),
      .care_i  (care[k]),
      .bit_o   (hist[k]),
      .agree_o (agree[k])
    );
  end

  // Saturating position count within the block.
  assign pos_new = (pos_q[POS_W-1] == 1'b0) ? pos_q + POS_W'(1) : pos_q;
  assign pos_d   = in_data_i.end_of_block ? '0 : pos_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  // Side information for the word in the compare stage.
  assign start_full        = pos_new - POS_W'(len_eff);
  assign side_a_d.last     = in_data_i.end_of_block;
  assign side_a_d.eligible = (len_eff != '0) && (pos_new >= POS_W'(len_eff));
  assign side_a_d.need     = need_eff;
  assign side_a_d.start    = start_full[START_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q <= side_a_d;
    end
  end

  // Count of agreeing bits and the report decision.
  tpd_count u_count (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_a_q),
    .agree_i  (agree),
    .side_i   (side_a_q),
    .valid_o  (valid_b),
    .result_o (result_b)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= result_b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
